[rtl/sfcs_pkg.sv]
// ----------------------------------------------------------------------------
// sfcs_pkg
// Types and command constants shared by the serial flash command sequencer.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned PAGE_BYTES   = 256;
  localparam int unsigned SECTOR_BITS  = $clog2(SECTOR_BYTES);

  localparam logic [16:0] BLOCK_BYTES_C  = 17'h10000;
  localparam logic [16:0] SECTOR_BYTES_C = 17'(SECTOR_BYTES);
  localparam logic [16:0] PAGE_BYTES_C   = 17'(PAGE_BYTES);
  localparam logic [25:0] ERASE_MAX_C    = 26'h1FFF000;

  // Flash command bytes
  localparam logic [7:0] CMD_READ        = 8'h03;
  localparam logic [7:0] CMD_PAGE_PROG   = 8'h02;
  localparam logic [7:0] CMD_WRITE_EN    = 8'h06;
  localparam logic [7:0] CMD_SECTOR_ERS  = 8'h20;
  localparam logic [7:0] CMD_BLOCK_ERS   = 8'hD8;
  localparam logic [7:0] CMD_CHIP_ERS    = 8'hC7;
  localparam logic [7:0] CMD_READ_STATUS = 8'h05;
  localparam logic [7:0] CMD_NONE        = 8'h00;

  // Input word function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DONE  = 1'b1;

  // Operation kinds of a start word
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_PROG  = 2'd1;
  localparam logic [1:0] KIND_ERASE = 2'd2;
  localparam logic [1:0] KIND_CHIP  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MAX_READ_CHUNK = 1'b0;
  localparam logic CFG_SMALL_ERASE_OK = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_READ  = 3'd1,
    MODE_PROG  = 3'd2,
    MODE_ERASE = 3'd3,
    MODE_CHIP  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_ZERO     = 4'd0,
    ST_READCMD  = 4'd1,
    ST_READDATA = 4'd2,
    ST_WREN     = 4'd3,
    ST_CMD      = 4'd4,
    ST_WDATA    = 4'd5,
    ST_STATUS   = 4'd6
  } step_t;

  typedef enum logic [2:0] {
    SEG_OPCODE   = 3'd0,
    SEG_OPADDR   = 3'd1,
    SEG_RDATA    = 3'd2,
    SEG_WDATA    = 3'd3,
    SEG_STATUS   = 3'd4,
    SEG_FINISHED = 3'd5
  } seg_kind_t;

  typedef struct packed {
    mode_t       mode;
    step_t       stp;
    logic [23:0] cur_address;
    logic [24:0] bytes_left;
    logic [23:0] data_offset;
    logic [16:0] chunk_bytes;
  } state_t;

  typedef struct packed {
    logic        func;
    logic [1:0]  op_kind;
    logic [23:0] start_address;
    logic [24:0] byte_length;
    logic [7:0]  status_byte;
  } item_t;

  typedef struct packed {
    seg_kind_t   seg_kind;
    logic [7:0]  opcode;
    logic [23:0] seg_address;
    logic [15:0] seg_count;
    logic [23:0] buffer_offset;
    logic        release_select;
  } seg_t;

  typedef struct packed {
    logic [15:0] max_read_chunk;
    logic        small_erase_ok;
  } cfg_t;

endpackage

[rtl/serial_flash_command_sequencer.sv]
// ----------------------------------------------------------------------------
// serial_flash_command_sequencer
// Serial NOR flash operation sequencer: at most one bus segment per input word.
// ----------------------------------------------------------------------------
// Each accepted input word is held in the input register; its segment is
//   registered in the segment register and then presented on out_*.
// Throughput: one word per cycle; the input register and the segment register
//   both advance in the same cycle unless out_stall holds a segment.
// Reset (rst_n low, synchronous): sequencer idle, registers at 65535 / 1,
//   pipeline empty.
module serial_flash_command_sequencer (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [1:0]  in_op_kind,
  input  logic [23:0] in_start_address,
  input  logic [24:0] in_byte_length,
  input  logic [7:0]  in_status_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_seg_kind,
  output logic [7:0]  out_opcode,
  output logic [23:0] out_seg_address,
  output logic [15:0] out_seg_count,
  output logic [23:0] out_buffer_offset,
  output logic        out_release_select,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import sfcs_pkg::*;

  state_t state_r;
  state_t state_nxt;
  cfg_t   cfg_r;
  logic   in_vld_r;
  item_t  item_r;
  logic   out_vld_r;
  logic   out_vld_nxt;
  seg_t   seg_r;
  seg_t   seg_nxt;
  logic   seg_vld;
  logic   adv;

  sfcs_step u_step (
    .st      (state_r),
    .item    (item_r),
    .cfg     (cfg_r),
    .st_nxt  (state_nxt),
    .seg_vld (seg_vld),
    .seg     (seg_nxt)
  );

  // advance the held word when the segment register is free or being drained
  assign adv         = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = in_vld_r && !adv;
  assign out_vld_nxt = adv ? seg_vld : (out_vld_r && out_stall);
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '{mode: MODE_IDLE, stp: ST_ZERO, default: '0};
      cfg_r     <= '{max_read_chunk: 16'hFFFF, small_erase_ok: 1'b1};
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        state_r <= state_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_READ_CHUNK: cfg_r.max_read_chunk <= cfg_data;
          CFG_SMALL_ERASE_OK: cfg_r.small_erase_ok <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= '{func: in_func, op_kind: in_op_kind, start_address: in_start_address,
                  byte_length: in_byte_length, status_byte: in_status_byte};
    end
    if (adv && seg_vld) begin
      seg_r <= seg_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_seg_kind       = seg_r.seg_kind;
  assign out_opcode         = seg_r.opcode;
  assign out_seg_address    = seg_r.seg_address;
  assign out_seg_count      = seg_r.seg_count;
  assign out_buffer_offset  = seg_r.buffer_offset;
  assign out_release_select = seg_r.release_select;

endmodule

[rtl/sfcs_step.sv]
// ----------------------------------------------------------------------------
// sfcs_step
// Next sequencer state and the next bus segment for one input word.
// ----------------------------------------------------------------------------
module sfcs_step (
  input  sfcs_pkg::state_t st,
  input  sfcs_pkg::item_t  item,
  input  sfcs_pkg::cfg_t   cfg,
  output sfcs_pkg::state_t st_nxt,
  output logic             seg_vld,
  output sfcs_pkg::seg_t   seg
);
  import sfcs_pkg::*;

  logic [15:0] lim;
  logic [24:0] bl_dec;
  logic [24:0] rn_bl;
  logic [16:0] rn_chunk;
  logic [16:0] page_chunk;
  logic        use_sector;
  logic [25:0] ers_total;
  logic [25:0] ers_len;
  logic [23:0] addr_adv;
  logic [23:0] off_adv;

  always_comb begin
    lim = (cfg.max_read_chunk == '0) ? 16'd1 : cfg.max_read_chunk;
    bl_dec = ({8'd0, st.chunk_bytes} >= st.bytes_left) ? '0
           : st.bytes_left - {8'd0, st.chunk_bytes};
    rn_bl = (st.stp == ST_READDATA) ? bl_dec : st.bytes_left;
    rn_chunk = (rn_bl < {9'd0, lim}) ? rn_bl[16:0] : {1'b0, lim};
    page_chunk = (st.bytes_left < {8'd0, PAGE_BYTES_C}) ? st.bytes_left[16:0]
               : PAGE_BYTES_C;
    use_sector = cfg.small_erase_ok &&
                 ((st.cur_address[15:0] != '0) ||
                  (st.bytes_left < {8'd0, BLOCK_BYTES_C}));
    // round the erase range out to whole sectors, saturate
    ers_total = {1'b0, item.byte_length}
              + {14'd0, item.start_address[SECTOR_BITS-1:0]}
              + 26'(SECTOR_BYTES - 1);
    ers_total[SECTOR_BITS-1:0] = '0;
    ers_len = (ers_total > ERASE_MAX_C) ? ERASE_MAX_C : ers_total;
    addr_adv = st.cur_address + st.chunk_bytes[23:0];
    off_adv  = st.data_offset + st.chunk_bytes[23:0];
  end

  always_comb begin
    st_nxt  = st;
    seg_vld = 1'b0;
    seg     = '{seg_kind: SEG_FINISHED, opcode: CMD_NONE, seg_address: '0,
                seg_count: '0, buffer_offset: '0, release_select: 1'b1};

    if (item.func == FUNC_START) begin
      if (st.mode == MODE_IDLE) begin
        seg_vld              = 1'b1;
        st_nxt.cur_address   = item.start_address;
        st_nxt.data_offset   = '0;
        st_nxt.chunk_bytes   = '0;
        st_nxt.bytes_left    = item.byte_length;
        case (item.op_kind)
          KIND_READ: begin
            if (item.byte_length == '0) begin
              st_nxt.mode = MODE_IDLE;
              st_nxt.stp  = ST_ZERO;
            end else begin
              st_nxt.mode = MODE_READ;
              st_nxt.stp  = ST_READCMD;
              seg.seg_kind       = SEG_OPADDR;
              seg.opcode         = CMD_READ;
              seg.seg_address    = item.start_address;
              seg.release_select = 1'b0;
            end
          end
          KIND_PROG, KIND_ERASE: begin
            if (item.op_kind == KIND_ERASE) begin
              st_nxt.cur_address = {item.start_address[23:SECTOR_BITS],
                                    {SECTOR_BITS{1'b0}}};
              st_nxt.bytes_left  = ers_len[24:0];
            end
            if (st_nxt.bytes_left == '0) begin
              st_nxt.mode = MODE_IDLE;
              st_nxt.stp  = ST_ZERO;
            end else begin
              st_nxt.mode  = (item.op_kind == KIND_ERASE) ? MODE_ERASE : MODE_PROG;
              st_nxt.stp   = ST_WREN;
              seg.seg_kind = SEG_OPCODE;
              seg.opcode   = CMD_WRITE_EN;
            end
          end
          default: begin
            st_nxt.mode       = MODE_CHIP;
            st_nxt.bytes_left = '0;
            st_nxt.stp        = ST_WREN;
            seg.seg_kind      = SEG_OPCODE;
            seg.opcode        = CMD_WRITE_EN;
          end
        endcase
      end
    end else if (st.mode != MODE_IDLE) begin
      seg_vld = 1'b1;
      case (st.stp)
        ST_READCMD, ST_READDATA: begin
          if (st.stp == ST_READDATA) begin
            st_nxt.data_offset = off_adv;
            st_nxt.bytes_left  = bl_dec;
          end
          if (rn_bl == '0) begin
            st_nxt.mode = MODE_IDLE;
            st_nxt.stp  = ST_ZERO;
          end else begin
            st_nxt.chunk_bytes = rn_chunk;
            st_nxt.stp         = ST_READDATA;
            seg.seg_kind       = SEG_RDATA;
            seg.seg_count      = rn_chunk[15:0];
            seg.buffer_offset  = st_nxt.data_offset;
            seg.release_select = 1'b0;
          end
        end
        ST_WREN: begin
          st_nxt.stp = ST_CMD;
          case (st.mode)
            MODE_PROG: begin
              seg.seg_kind    = SEG_OPADDR;
              seg.opcode      = CMD_PAGE_PROG;
              seg.seg_address = st.cur_address;
            end
            MODE_ERASE: begin
              st_nxt.chunk_bytes = use_sector ? SECTOR_BYTES_C : BLOCK_BYTES_C;
              seg.seg_kind       = SEG_OPADDR;
              seg.opcode         = use_sector ? CMD_SECTOR_ERS : CMD_BLOCK_ERS;
              seg.seg_address    = st.cur_address;
            end
            default: begin
              seg.seg_kind = SEG_OPCODE;
              seg.opcode   = CMD_CHIP_ERS;
            end
          endcase
        end
        ST_CMD, ST_WDATA: begin
          if (st.stp == ST_CMD && st.mode == MODE_PROG) begin
            st_nxt.chunk_bytes = page_chunk;
            st_nxt.stp         = ST_WDATA;
            seg.seg_kind       = SEG_WDATA;
            seg.seg_count      = page_chunk[15:0];
            seg.buffer_offset  = st.data_offset;
          end else begin
            st_nxt.stp    = ST_STATUS;
            seg.seg_kind  = SEG_STATUS;
            seg.opcode    = CMD_READ_STATUS;
            seg.seg_count = 16'd1;
          end
        end
        ST_STATUS: begin
          if (item.status_byte[0]) begin
            // still busy: poll again
            seg.seg_kind  = SEG_STATUS;
            seg.opcode    = CMD_READ_STATUS;
            seg.seg_count = 16'd1;
          end else if (st.mode == MODE_CHIP) begin
            st_nxt.mode = MODE_IDLE;
            st_nxt.stp  = ST_ZERO;
          end else begin
            st_nxt.cur_address = addr_adv;
            if (st.mode == MODE_PROG) begin
              st_nxt.data_offset = off_adv;
            end
            st_nxt.bytes_left = bl_dec;
            if (bl_dec == '0) begin
              st_nxt.mode = MODE_IDLE;
              st_nxt.stp  = ST_ZERO;
            end else begin
              st_nxt.stp   = ST_WREN;
              seg.seg_kind = SEG_OPCODE;
              seg.opcode   = CMD_WRITE_EN;
            end
          end
        end
        default: begin
          st_nxt.mode = MODE_IDLE;
          st_nxt.stp  = ST_ZERO;
        end
      endcase
    end
  end

endmodule
